// ===== rtl/core/cphe_pkg.sv =====
// Shared types and constants of the container packet header encoder.
// No dependencies; imported by cphe_hdr_build and the top level.
`timescale 1ns / 1ps
package cphe_pkg;

  localparam int STREAM_COUNT  = 16;
  localparam int IDX_W         = $clog2(STREAM_COUNT);
  localparam int HDR_MAX_BYTES = 22;
  localparam int HDR_BITS      = HDR_MAX_BYTES * 8;
  localparam int CNT_W         = $clog2(HDR_MAX_BYTES + 1);
  localparam int PTS_W         = 40;
  localparam int LEN_W         = 48;
  localparam int SN_W          = 4;
  localparam int THR_W         = 16;
  localparam int MEM_W         = 2 * PTS_W + LEN_W;

  // Flag byte fields
  localparam logic [7:0] FLG_ID  = 8'h80;
  localparam logic [7:0] FLG_LEN = 8'h40;
  localparam logic [7:0] FLG_PTS = 8'h20;

  // Type and marker bytes
  localparam logic [7:0] TYPE_SEEK  = 8'h4B; // 'K'
  localparam logic [7:0] TYPE_KEY   = 8'h44; // 'D'
  localparam logic [7:0] TYPE_OTHER = 8'h64; // 'd'
  localparam logic [7:0] MARK_S     = 8'h53; // 'S'
  localparam logic [7:0] MARK_E     = 8'h45; // 'E'

  // Configuration register indexes
  localparam logic [1:0] CFG_DV_PRESENT = 2'd0;
  localparam logic [1:0] CFG_DV_ID      = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
  localparam logic [1:0] CFG_BASE_OFS   = 2'd3;

  // Stored and configured state seen by the header builder
  typedef struct packed {
    logic             first_done;
    logic             seek_seen;
    logic [PTS_W-1:0] last_seek_ms;
    logic [SN_W-1:0]  last_stream;
    logic             pts_known;
    logic             delta_known;
    logic [PTS_W-1:0] prior_pts;
    logic [PTS_W-1:0] prior_delta;
    logic [LEN_W-1:0] prior_length;
    logic             dv_present;
    logic [SN_W-1:0]  dv_id;
    logic [THR_W-1:0] threshold;
  } ctx_t;

  // Header builder decision
  typedef struct packed {
    logic [HDR_BITS-1:0] hdr;
    logic [CNT_W-1:0]    hlen;
    logic                seek;
    logic                delta_path;
    logic [PTS_W-1:0]    xpts;
  } hdr_t;

endpackage

// ===== rtl/core/container_packet_header_encoder.sv =====
// Top level of the container packet header encoder: input stage, per-stream
// history memory, header buffer and byte serialiser. Depends on cphe_pkg, cphe_hdr_build.
`timescale 1ns / 1ps
// One descriptor item in, its header out as 2 to 22 byte items, one per cycle
// while m_axis_tready holds, the final one with tlast; tuser marks a seek point
// and every byte carries the file offset of the header. An item waits in the
// input stage while the stream history memory is read, then is encoded as soon
// as the header buffer empties, and the next descriptor is accepted while the
// header bytes drain. No reset clearing pass: per-stream history is only read
// after the stream was written.
module container_packet_header_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stream_num[3:0], payload_length[51:4], pts_ms[91:52], zero pad
  input  logic [95:0] s_axis_tdata,
  // key_frame[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // header_byte[7:0], packet_offset[55:8]
  output logic [55:0] m_axis_tdata,
  // seek_point[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import cphe_pkg::*;

  // Configuration
  logic             dv_present_q;
  logic [SN_W-1:0]  dv_id_q;
  logic [THR_W-1:0] threshold_q;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Scalar state and valid bits
  logic                    first_done_q, seek_seen_q;
  logic [PTS_W-1:0]        last_seek_q;
  logic [SN_W-1:0]         last_stream_q;
  logic [LEN_W-1:0]        wr_ofs_q;
  logic [STREAM_COUNT-1:0] pts_known_q, delta_known_q;

  // Input stage
  logic             s1_v_q;
  logic [SN_W-1:0]  s1_sn_q;
  logic [LEN_W-1:0] s1_len_q;
  logic             s1_key_q;
  logic [PTS_W-1:0] s1_pts_q;
  logic [IDX_W-1:0] s1_idx;

  // History memory {pts, delta, length} and forwarding
  logic [MEM_W-1:0] mem_q [STREAM_COUNT];
  logic [MEM_W-1:0] rdata_q, fwd_data_q, hist, wdata;
  logic             fwd_q;

  // Output buffer
  logic                ob_v_q, ob_seek_q;
  logic [HDR_BITS-1:0] ob_hdr_q;
  logic [CNT_W-1:0]    ob_cnt_q;
  logic [LEN_W-1:0]    ob_ofs_q;

  logic   in_acc, out_acc, buf_free, do_compute;
  logic [IDX_W-1:0] in_idx;
  ctx_t   ctx;
  hdr_t   res;

  assign in_idx     = s_axis_tdata[IDX_W-1:0];
  assign s1_idx     = s1_sn_q[IDX_W-1:0];
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign buf_free   = !ob_v_q || (out_acc && m_axis_tlast);
  assign do_compute = s1_v_q && buf_free;
  assign s_axis_tready = !s1_v_q || do_compute;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign hist       = fwd_q ? fwd_data_q : rdata_q;

  // Gather the context for the header builder
  always_comb begin
    ctx.first_done   = first_done_q;
    ctx.seek_seen    = seek_seen_q;
    ctx.last_seek_ms = last_seek_q;
    ctx.last_stream  = last_stream_q;
    ctx.pts_known    = pts_known_q[s1_idx];
    ctx.delta_known  = delta_known_q[s1_idx];
    ctx.prior_pts    = hist[MEM_W-1 -: PTS_W];
    ctx.prior_delta  = hist[LEN_W +: PTS_W];
    ctx.prior_length = hist[LEN_W-1:0];
    ctx.dv_present   = dv_present_q;
    ctx.dv_id        = dv_id_q;
    ctx.threshold    = threshold_q;
  end

  cphe_hdr_build u_build (
    .sn_i  (s1_sn_q),
    .len_i (s1_len_q),
    .key_i (s1_key_q),
    .pts_i (s1_pts_q),
    .ctx_i (ctx),
    .res_o (res)
  );

  assign wdata = {s1_pts_q, (res.delta_path ? res.xpts : PTS_W'(0)), s1_len_q};

  // Hold the input item while its history is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
        fwd_q  <= do_compute && (in_idx == s1_idx);
      end else if (do_compute) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sn_q    <= s_axis_tdata[3:0];
      s1_len_q   <= s_axis_tdata[51:4];
      s1_pts_q   <= s_axis_tdata[91:52];
      s1_key_q   <= s_axis_tuser[0];
      fwd_data_q <= wdata;
    end
  end

  // Read and write back the history memory
  always_ff @(posedge clk_i) begin
    if (do_compute) mem_q[s1_idx] <= wdata;
    if (in_acc)     rdata_q <= mem_q[in_idx];
  end

  // Update configuration and scalar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_present_q  <= 1'b0;
      dv_id_q       <= '0;
      threshold_q   <= THR_W'(1000);
      first_done_q  <= 1'b0;
      seek_seen_q   <= 1'b0;
      last_seek_q   <= '0;
      last_stream_q <= '0;
      wr_ofs_q      <= '0;
      pts_known_q   <= '0;
      delta_known_q <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index_i)
          CFG_DV_PRESENT: dv_present_q <= cfg_data_i[0];
          CFG_DV_ID:      dv_id_q      <= cfg_data_i[SN_W-1:0];
          CFG_THRESHOLD:  threshold_q  <= cfg_data_i[THR_W-1:0];
          CFG_BASE_OFS:   wr_ofs_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_compute) begin
        first_done_q  <= 1'b1;
        last_stream_q <= s1_sn_q;
        wr_ofs_q      <= wr_ofs_q + LEN_W'(res.hlen) + s1_len_q;
        if (res.seek) begin
          seek_seen_q <= 1'b1;
          last_seek_q <= s1_pts_q;
          pts_known_q <= STREAM_COUNT'(1) << s1_idx;
        end else begin
          pts_known_q[s1_idx] <= 1'b1;
        end
        delta_known_q[s1_idx] <= res.delta_path;
      end
    end
  end

  // Load the header buffer and shift out one byte per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_v_q   <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      if (do_compute) begin
        ob_v_q   <= 1'b1;
        ob_cnt_q <= res.hlen;
      end else if (out_acc) begin
        ob_v_q   <= !m_axis_tlast;
        ob_cnt_q <= ob_cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_compute) begin
      ob_hdr_q  <= res.hdr;
      ob_seek_q <= res.seek;
      ob_ofs_q  <= wr_ofs_q;
    end else if (out_acc) begin
      ob_hdr_q <= ob_hdr_q >> 8;
    end
  end

  assign m_axis_tvalid = ob_v_q;
  assign m_axis_tdata  = {ob_ofs_q, ob_hdr_q[7:0]};
  assign m_axis_tuser  = ob_seek_q;
  assign m_axis_tlast  = (ob_cnt_q == CNT_W'(1));

`ifndef NO_ASSERTIONS
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_v_q |-> (ob_cnt_q != '0) && (ob_cnt_q <= CNT_W'(HDR_MAX_BYTES)))
    else $error("header buffer count out of range");
  a_fwd_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_q && !$past(in_acc)) |-> $stable(fwd_q))
    else $error("forward flag changed without an accepted item");
  a_min_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_compute |=> (ob_cnt_q >= CNT_W'(2)))
    else $error("header shorter than two bytes");
  a_seek_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_compute && res.seek) |=> $onehot(pts_known_q))
    else $error("seek point left other streams known");
`endif

endmodule

// ===== rtl/core/cphe_hdr_build.sv =====
// Seek point decision and header byte assembly for one packet descriptor.
// Depends on cphe_pkg.
`timescale 1ns / 1ps
module cphe_hdr_build (
  input  logic [cphe_pkg::SN_W-1:0]  sn_i,
  input  logic [cphe_pkg::LEN_W-1:0] len_i,
  input  logic                       key_i,
  input  logic [cphe_pkg::PTS_W-1:0] pts_i,
  input  cphe_pkg::ctx_t             ctx_i,
  output cphe_pkg::hdr_t             res_o
);
  import cphe_pkg::*;

  logic             seek, want_abs, dv_ok, gap_ok;
  logic             len_f, pts_f, id_f, delta_path;
  logic [PTS_W-1:0] pts_gap, xpts;
  logic [1:0]       lcode, pcode;
  logic [7:0]       flg, typ;
  logic [CNT_W-1:0] lbytes, pbytes;

  // Decide the seek point and the field sizes
  always_comb begin
    pts_gap  = pts_i - ctx_i.last_seek_ms;
    gap_ok   = (pts_i >= ctx_i.last_seek_ms) && (pts_gap >= PTS_W'(ctx_i.threshold));
    dv_ok    = !ctx_i.dv_present || (sn_i == ctx_i.dv_id);
    seek     = !ctx_i.first_done || (key_i && dv_ok && (!ctx_i.seek_seen || gap_ok));
    want_abs = !ctx_i.pts_known || seek;

    if (len_i < LEN_W'(48'h100))             lcode = 2'd0;
    else if (len_i < LEN_W'(48'h10000))      lcode = 2'd1;
    else if (len_i < LEN_W'(48'h1_0000_0000)) lcode = 2'd2;
    else                                      lcode = 2'd3;
    len_f = !((len_i == ctx_i.prior_length) && !want_abs);

    delta_path = !want_abs && (pts_i >= ctx_i.prior_pts);
    xpts       = delta_path ? (pts_i - ctx_i.prior_pts) : pts_i;
    pts_f      = !(delta_path && ctx_i.delta_known && (xpts == ctx_i.prior_delta));

    if (xpts < PTS_W'(40'h100) && !want_abs)            pcode = 2'd0;
    else if (xpts < PTS_W'(40'h10000) && !want_abs)     pcode = 2'd1;
    else if (xpts < PTS_W'(40'h1_0000_0000))            pcode = 2'd2;
    else                                                pcode = 2'd3;

    id_f = !((sn_i == ctx_i.last_stream) && !want_abs);

    flg = {6'd0, pcode} << 2;
    if (len_f) flg = flg | FLG_LEN | {6'd0, lcode};
    if (pts_f) flg = flg | FLG_PTS;
    if (id_f)  flg = flg | FLG_ID;

    typ    = seek ? TYPE_SEEK : (key_i ? TYPE_KEY : TYPE_OTHER);
    lbytes = CNT_W'(1) << lcode;
    pbytes = CNT_W'(1) << pcode;
  end

  logic [HDR_BITS-1:0] hdr;
  logic [CNT_W-1:0]    pos;

  // Pack the header bytes, first byte lowest; field values fit their size codes
  always_comb begin
    hdr = '0;
    pos = '0;
    if (seek) begin
      hdr = HDR_BITS'({MARK_E, MARK_E, MARK_S});
      pos = CNT_W'(3);
    end
    hdr = hdr | (HDR_BITS'({flg, typ}) << {pos, 3'b000});
    pos = pos + CNT_W'(2);
    if (id_f) begin
      hdr = hdr | (HDR_BITS'({4'd0, sn_i}) << {pos, 3'b000});
      pos = pos + CNT_W'(1);
    end
    if (len_f) begin
      hdr = hdr | (HDR_BITS'(len_i) << {pos, 3'b000});
      pos = pos + lbytes;
    end
    if (pts_f) begin
      hdr = hdr | (HDR_BITS'(xpts) << {pos, 3'b000});
      pos = pos + pbytes;
    end
  end

  assign res_o.hdr        = hdr;
  assign res_o.hlen       = pos;
  assign res_o.seek       = seek;
  assign res_o.delta_path = delta_path;
  assign res_o.xpts       = xpts;

endmodule
